// ===== hw/rtl/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted value table package
// Shared sizes, operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package svt_pkg;

  // Table size and derived widths.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // One result as it leaves the sequencer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } svt_result_t;

endpackage

// ===== hw/rtl/sorted_value_table.sv =====
// ----------------------------------------------------------------------------
// Sorted value table
// Ascending table of signed values with insert, delete and search requests.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY signed 32-bit values in ascending order in a
// single-port-read, single-port-write RAM. One request is worked on at a
// time: an insert walks down from the tail moving entries not below the
// value up, a delete walks up from the head and moves the entries past the
// match down, and a search walks up until it meets a value not below the
// requested one. Each visited entry is read through the RAM read port. An
// unused operation code leaves the table unchanged and reports done. The
// result sits in an output register, so the next request is taken while the
// previous result waits to be read.
module sorted_value_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [svt_pkg::OP_W-1:0]           op_i,
  input  logic signed [svt_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [svt_pkg::STATUS_W-1:0]       status_o,
  output logic                               found_o,
  output logic [svt_pkg::COUNT_W-1:0]        count_o
);

  import svt_pkg::*;

  logic                seq_idle;
  logic                res_valid;
  logic                res_ready;
  svt_result_t         res;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;
  logic                out_valid_q;
  svt_result_t         out_q;

  // Entry storage.
  svt_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (VALUE_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Request sequencer.
  svt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .op_i        (op_i),
    .value_i     (value_i),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign in_ready_o = seq_idle;
  assign res_ready  = !out_valid_q || out_ready_i;

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign found_o     = out_q.found;
  assign count_o     = out_q.count;

  // A result that reports a found value never reports it missing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o != ST_MISSING))
    else $error("found result carries a not-found status");

  // A refused insert only happens on a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (count_o == COUNT_W'(CAPACITY)))
    else $error("table-full status with a count below capacity");

  // The sequencer is not ready in the cycle after it accepts a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer ready again right after taking a request");

  // The sequencer never writes and reads the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("RAM write and read collide on one entry");

endmodule

// ===== hw/rtl/svt_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted value table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module svt_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/svt_seq.sv =====
// ----------------------------------------------------------------------------
// Sorted value table sequencer
// Walks the stored entries through the RAM read port and shifts them through
// the write port to insert, delete or search one value per request.
// ----------------------------------------------------------------------------
module svt_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic [svt_pkg::OP_W-1:0]         op_i,
  input  logic signed [svt_pkg::VALUE_W-1:0] value_i,
  output logic                             idle_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output svt_pkg::svt_result_t             res_o,
  output logic                             mem_we_o,
  output logic [svt_pkg::ADDR_W-1:0]       mem_waddr_o,
  output logic [svt_pkg::VALUE_W-1:0]      mem_wdata_o,
  output logic                             mem_re_o,
  output logic [svt_pkg::ADDR_W-1:0]       mem_raddr_o,
  input  logic [svt_pkg::VALUE_W-1:0]      mem_rdata_i
);

  import svt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 found_q, found_d;
  logic                 hit_q, hit_d;

  logic                 last;
  logic                 ge;
  logic                 eq;
  logic                 full;

  // Compare the entry just read against the requested value, and flag the last stored entry and a full table.
  assign last = ((CNT_W'(addr_q) + CNT_W'(1)) == cnt_q);
  assign ge   = ($signed(mem_rdata_i) >= $signed(val_q));
  assign eq   = (mem_rdata_i == val_q);
  assign full = (cnt_q >= CNT_W'(CAPACITY));

  // Next state and RAM port control.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    status_d    = status_q;
    found_d     = found_q;
    hit_d       = hit_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q + ADDR_W'(1);
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = op_i;
          val_d   = value_i;
          found_d = 1'b0;
          hit_d   = 1'b0;
          case (op_i)
            OP_INSERT: begin
              if (full) begin
                // Full table: only look for the value.
                status_d    = ST_FULL;
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                addr_d      = '0;
                state_d     = S_SCAN;
              end else if (cnt_q == '0) begin
                status_d    = ST_DONE;
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = value_i;
                cnt_d       = cnt_q + CNT_W'(1);
                state_d     = S_DONE;
              end else begin
                // Walk down from the tail, moving entries not below the value up.
                status_d    = ST_DONE;
                mem_re_o    = 1'b1;
                mem_raddr_o = ADDR_W'(cnt_q - CNT_W'(1));
                addr_d      = ADDR_W'(cnt_q - CNT_W'(1));
                state_d     = S_INS;
              end
            end
            OP_DELETE, OP_SEARCH: begin
              status_d = ST_MISSING;
              if (cnt_q == '0) begin
                state_d = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                addr_d      = '0;
                state_d     = S_SCAN;
              end
            end
            default: begin
              status_d = ST_DONE;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q + ADDR_W'(1);
        if (ge) begin
          mem_wdata_o = mem_rdata_i;
          if (eq) begin
            found_d = 1'b1;
          end
          if (addr_q == '0) begin
            state_d = S_PUT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = addr_q - ADDR_W'(1);
            addr_d      = addr_q - ADDR_W'(1);
          end
        end else begin
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CNT_W'(1);
          state_d     = S_DONE;
        end
      end

      S_PUT: begin
        // Every entry was moved up, so the value lands at the head.
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CNT_W'(1);
        state_d     = S_DONE;
      end

      S_SCAN: begin
        if (hit_q) begin
          // Close the gap left by the deleted entry.
          mem_we_o    = 1'b1;
          mem_waddr_o = addr_q - ADDR_W'(1);
          mem_wdata_o = mem_rdata_i;
          if (last) begin
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            mem_re_o = 1'b1;
            addr_d   = addr_q + ADDR_W'(1);
          end
        end else if (eq) begin
          found_d = 1'b1;
          if (op_q == OP_DELETE) begin
            status_d = ST_DONE;
            if (last) begin
              cnt_d   = cnt_q - CNT_W'(1);
              state_d = S_DONE;
            end else begin
              hit_d    = 1'b1;
              mem_re_o = 1'b1;
              addr_d   = addr_q + ADDR_W'(1);
            end
          end else begin
            if (op_q == OP_SEARCH) begin
              status_d = ST_DONE;
            end
            state_d = S_DONE;
          end
        end else if (ge || last) begin
          state_d = S_DONE;
        end else begin
          mem_re_o = 1'b1;
          addr_d   = addr_q + ADDR_W'(1);
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      status_q <= ST_DONE;
      op_q     <= OP_SEARCH;
      addr_q   <= '0;
      val_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      found_q  <= found_d;
      status_q <= status_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      val_q    <= val_d;
    end
  end

  assign idle_o       = (state_q == S_IDLE);
  assign res_o.status = status_q;
  assign res_o.found  = found_q;
  assign res_o.count  = COUNT_W'(cnt_q);

endmodule
